// File: src/ufd_pkg.sv
// shared constants, codes and control/status structs of the frame decoder
// depends on nothing; imported by the interfaces and every decoder module except ufd_ram
package ufd_pkg;

   localparam int MAX_PAYLOAD = 64;
   localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
   localparam int IDX_W       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int BYTE_W      = 8;
   localparam int FUNC_W      = 16;
   localparam int STATUS_W    = 2;

   localparam logic [BYTE_W-1:0] START_RESET = 8'hFE;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_SUM  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd2;

   // kind of result loaded into the output register
   localparam logic [1:0] OUT_BYTE     = 2'd0;
   localparam logic [1:0] OUT_EMPTY    = 2'd1;
   localparam logic [1:0] OUT_BAD_SUM  = 2'd2;
   localparam logic [1:0] OUT_TOO_LONG = 2'd3;

   typedef struct packed {
      logic       ld_start;
      logic       ld_func_hi;
      logic       ld_func_lo;
      logic       ld_len_hi;
      logic       ld_len_lo;
      logic       ld_data;
      logic       emit_start;
      logic       rd_en;
      logic       out_load;
      logic [1:0] out_kind;
   } ufd_cmd_type;

   typedef struct packed {
      logic is_start;
      logic len_too_long;
      logic len_in_zero;
      logic len_zero;
      logic data_done;
      logic sum_match;
      logic emit_last;
      logic out_free;
   } ufd_stat_type;

endpackage

// File: src/ufd_if.sv
// handshake channel interfaces: received bytes, results, start byte register
// depends on ufd_pkg for field widths
interface ufd_req_if
   import ufd_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ufd_rsp_if
   import ufd_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [FUNC_W-1:0]   function_code;
   logic [LEN_W-1:0]    payload_length;
   logic [IDX_W-1:0]    byte_index;
   logic [BYTE_W-1:0]   payload_byte;
   logic                byte_valid;
   logic                last;

   modport source (output valid, output status, output function_code,
                   output payload_length, output byte_index, output payload_byte,
                   output byte_valid, output last, input ready);
   modport sink   (input valid, input status, input function_code,
                   input payload_length, input byte_index, input payload_byte,
                   input byte_valid, input last, output ready);
endinterface

interface ufd_csr_if
   import ufd_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] start_byte;

   modport source (output valid, output start_byte, input ready);
   modport sink   (input valid, input start_byte, output ready);
endinterface

// File: src/ufd_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module ufd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/ufd_ctrl.sv
// frame parser and result sequencer state machine
// depends on ufd_pkg; drives ufd_datapath through ufd_cmd_type
module ufd_ctrl
   import ufd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ufd_stat_type stat,
   output ufd_cmd_type  cmd
);

   localparam logic [3:0] S_WAIT    = 4'd0;
   localparam logic [3:0] S_FUNC_HI = 4'd1;
   localparam logic [3:0] S_FUNC_LO = 4'd2;
   localparam logic [3:0] S_LEN_HI  = 4'd3;
   localparam logic [3:0] S_LEN_LO  = 4'd4;
   localparam logic [3:0] S_DATA    = 4'd5;
   localparam logic [3:0] S_CHECK   = 4'd6;
   localparam logic [3:0] S_EMIT_RD = 4'd7;
   localparam logic [3:0] S_EMIT_WR = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       fire;

   always_comb begin
      req_ready = 1'b0;
      unique case (state_ff) inside
         S_EMIT_RD, S_EMIT_WR: req_ready = 1'b0;
         default:              req_ready = stat.out_free;
      endcase
   end

   assign fire = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_WAIT: begin
            if (fire && stat.is_start) begin
               cmd.ld_start = 1'b1;
               state_in     = S_FUNC_HI;
            end
         end
         S_FUNC_HI: begin
            if (fire) begin
               cmd.ld_func_hi = 1'b1;
               state_in       = S_FUNC_LO;
            end
         end
         S_FUNC_LO: begin
            if (fire) begin
               cmd.ld_func_lo = 1'b1;
               state_in       = S_LEN_HI;
            end
         end
         S_LEN_HI: begin
            if (fire) begin
               cmd.ld_len_hi = 1'b1;
               state_in      = S_LEN_LO;
            end
         end
         S_LEN_LO: begin
            if (fire) begin
               cmd.ld_len_lo = 1'b1;
               if (stat.len_too_long) begin
                  cmd.out_load = 1'b1;
                  cmd.out_kind = OUT_TOO_LONG;
                  state_in     = S_WAIT;
               end else if (stat.len_in_zero) begin
                  state_in = S_CHECK;
               end else begin
                  state_in = S_DATA;
               end
            end
         end
         S_DATA: begin
            if (fire) begin
               cmd.ld_data = 1'b1;
               if (stat.data_done) begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (fire) begin
               if (!stat.sum_match) begin
                  cmd.out_load = 1'b1;
                  cmd.out_kind = OUT_BAD_SUM;
                  state_in     = S_WAIT;
               end else if (stat.len_zero) begin
                  cmd.out_load = 1'b1;
                  cmd.out_kind = OUT_EMPTY;
                  state_in     = S_WAIT;
               end else begin
                  cmd.emit_start = 1'b1;
                  state_in       = S_EMIT_RD;
               end
            end
         end
         S_EMIT_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_EMIT_WR;
         end
         S_EMIT_WR: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = OUT_BYTE;
               state_in     = stat.emit_last ? S_WAIT : S_EMIT_RD;
            end
         end
         default: begin
            state_in = S_WAIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_WAIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: src/ufd_datapath.sv
// frame registers, running xor, payload buffer and output register
// depends on ufd_pkg, ufd_if and ufd_ram; commanded by ufd_ctrl
module ufd_datapath
   import ufd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [BYTE_W-1:0] rx_byte,
   ufd_csr_if.sink           csr_if,
   ufd_rsp_if.source         rsp_if,
   input  ufd_cmd_type       cmd,
   output ufd_stat_type      stat
);

   logic [BYTE_W-1:0]   start_byte_ff;
   logic [FUNC_W-1:0]   function_ff;
   logic [BYTE_W-1:0]   len_hi_ff;
   logic [LEN_W-1:0]    length_ff;
   logic [LEN_W-1:0]    count_ff;
   logic [BYTE_W-1:0]   xor_ff;
   logic [IDX_W-1:0]    emit_idx_ff;
   logic [BYTE_W-1:0]   rd_data;
   logic [15:0]         len_full;
   logic [LEN_W-1:0]    count_inc;
   logic [LEN_W-1:0]    emit_next;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [LEN_W-1:0]    out_len_ff;
   logic [IDX_W-1:0]    out_idx_ff;
   logic [BYTE_W-1:0]   out_byte_ff;
   logic                out_bvalid_ff;
   logic                out_last_ff;

   assign csr_if.ready = 1'b1;
   assign len_full     = {len_hi_ff, rx_byte};
   assign count_inc    = count_ff + LEN_W'(1);
   assign emit_next    = {1'b0, emit_idx_ff} + LEN_W'(1);

   assign stat.is_start     = (rx_byte == start_byte_ff);
   assign stat.len_too_long = (len_full > 16'(MAX_PAYLOAD));
   assign stat.len_in_zero  = (len_full == 16'd0);
   assign stat.len_zero     = (length_ff == '0);
   assign stat.data_done    = (count_inc >= length_ff);
   assign stat.sum_match    = (rx_byte == xor_ff);
   assign stat.emit_last    = (emit_next == length_ff);
   assign stat.out_free     = !rsp_valid_ff || rsp_if.ready;

   ufd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_PAYLOAD)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.ld_data),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (rx_byte),
      .rd_en   (cmd.rd_en),
      .rd_addr (emit_idx_ff),
      .rd_data (rd_data)
   );

   // start byte register
   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= START_RESET;
      end else if (csr_if.valid) begin
         start_byte_ff <= csr_if.start_byte;
      end
   end

   // frame fields and checksum
   always_ff @(posedge clock) begin
      if (reset) begin
         function_ff <= '0;
         len_hi_ff   <= '0;
         length_ff   <= '0;
         count_ff    <= '0;
         xor_ff      <= '0;
         emit_idx_ff <= '0;
      end else begin
         if (cmd.ld_start) begin
            xor_ff <= rx_byte;
         end
         if (cmd.ld_func_hi || cmd.ld_func_lo || cmd.ld_len_hi || cmd.ld_len_lo ||
             cmd.ld_data) begin
            xor_ff <= xor_ff ^ rx_byte;
         end
         if (cmd.ld_func_hi) begin
            function_ff <= {rx_byte, 8'h00};
         end
         if (cmd.ld_func_lo) begin
            function_ff[7:0] <= rx_byte;
         end
         if (cmd.ld_len_hi) begin
            len_hi_ff <= rx_byte;
         end
         if (cmd.ld_len_lo) begin
            length_ff <= len_full[LEN_W-1:0];
            count_ff  <= '0;
         end
         if (cmd.ld_data) begin
            count_ff <= count_inc;
         end
         if (cmd.emit_start) begin
            emit_idx_ff <= '0;
         end
         if (cmd.out_load && cmd.out_kind == OUT_BYTE) begin
            emit_idx_ff <= emit_next[IDX_W-1:0];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         unique case (cmd.out_kind)
            OUT_BYTE: begin
               status_ff     <= ST_OK;
               out_len_ff    <= length_ff;
               out_idx_ff    <= emit_idx_ff;
               out_byte_ff   <= rd_data;
               out_bvalid_ff <= 1'b1;
               out_last_ff   <= stat.emit_last;
            end
            OUT_EMPTY: begin
               status_ff     <= ST_OK;
               out_len_ff    <= '0;
               out_idx_ff    <= '0;
               out_byte_ff   <= '0;
               out_bvalid_ff <= 1'b0;
               out_last_ff   <= 1'b1;
            end
            OUT_BAD_SUM: begin
               status_ff     <= ST_BAD_SUM;
               out_len_ff    <= length_ff;
               out_idx_ff    <= '0;
               out_byte_ff   <= '0;
               out_bvalid_ff <= 1'b0;
               out_last_ff   <= 1'b1;
            end
            default: begin
               status_ff     <= ST_TOO_LONG;
               out_len_ff    <= '0;
               out_idx_ff    <= '0;
               out_byte_ff   <= '0;
               out_bvalid_ff <= 1'b0;
               out_last_ff   <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.status         = status_ff;
   assign rsp_if.function_code  = function_ff;
   assign rsp_if.payload_length = out_len_ff;
   assign rsp_if.byte_index     = out_idx_ff;
   assign rsp_if.payload_byte   = out_byte_ff;
   assign rsp_if.byte_valid     = out_bvalid_ff;
   assign rsp_if.last           = out_last_ff;

endmodule

// File: src/uart_frame_decoder_core.sv
// top level of the serial frame decoder
// depends on ufd_pkg, ufd_if, ufd_ctrl and ufd_datapath
//
// frame decoder for a byte stream: start byte, 16-bit function code and
// 16-bit payload length (both msb first), payload bytes, then one checksum
// byte equal to the xor of every byte from the start byte through the last
// payload byte. bytes other than the start byte are dropped while idle.
// a good frame comes out as one transaction per payload byte, last set on
// the final one; a zero-length frame gives one transaction with byte_valid
// low. a checksum mismatch (status 1) or a length above 64 (status 2, seen
// right after the length bytes) gives a single transaction and the frame
// is discarded. the start byte register resets to 0xfe and is written over
// the csr channel; the user must write it only while the decoder is idle,
// the block itself does not enforce this. a frame already under way keeps
// the start byte it began with as checksum seed. received bytes can stream
// back to back while the output register is free. after a good checksum
// byte the payload is read back from a 64-entry buffer ram; each result
// transaction takes a ram read, then an output register load that waits
// while the sink stalls. no byte is taken during that burst. while a status
// transaction waits in the output register for the sink, no byte is taken;
// the cycle it leaves, the next byte can enter.
module uart_frame_decoder_core
   import ufd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   ufd_req_if.sink   req_if,
   ufd_rsp_if.source rsp_if,
   ufd_csr_if.sink   csr_if
);

   ufd_cmd_type  cmd;
   ufd_stat_type stat;

   // parser and result sequencer
   ufd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // frame registers, payload buffer and output register
   ufd_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .rx_byte (req_if.rx_byte),
      .csr_if  (csr_if),
      .rsp_if  (rsp_if),
      .cmd     (cmd),
      .stat    (stat)
   );

endmodule

// File: tb/tb_uart_frame_decoder_core.sv
// self-checking bench for uart_frame_decoder_core: random and directed byte streams
// depends on ufd_pkg, the ufd_req_if, ufd_rsp_if and ufd_csr_if interfaces and uart_frame_decoder_core
module tb_uart_frame_decoder_core
   import ufd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
   localparam int SETTLE_CYCLES  = 16;    // room for a status still held in the output register
   localparam int PHASE_BYTES    = 48;    // random bytes per start byte setting
   localparam int NUM_PHASES     = 5;

   // parser position, one per byte of the frame layout
   typedef enum logic [2:0] {
      PH_WAIT, PH_FUNC_HI, PH_FUNC_LO, PH_LEN_HI, PH_LEN_LO, PH_DATA, PH_CHECK
   } parse_phase_type;

   // one result transaction as it leaves the decoder
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FUNC_W-1:0]   function_code;
      logic [LEN_W-1:0]    payload_length;
      logic [IDX_W-1:0]    byte_index;
      logic [BYTE_W-1:0]   payload_byte;
      logic                byte_valid;
      logic                last;
   } frame_result_type;

   // tracks the parser state of the decoder and holds the results it owes
   class frame_decode_tracker_type;
      logic [BYTE_W-1:0] start_val;
      parse_phase_type   phase;
      logic [15:0]       func_acc;
      logic [15:0]       len_acc;
      logic [6:0]        count;
      logic [BYTE_W-1:0] sum;
      logic [BYTE_W-1:0] store [MAX_PAYLOAD];
      frame_result_type  owed_results [$];
      int                fail_count;

      function new();
         start_val  = START_RESET;
         phase      = PH_WAIT;
         func_acc   = '0;
         len_acc    = '0;
         count      = '0;
         sum        = '0;
         fail_count = 0;
      endfunction

      function void set_start(logic [BYTE_W-1:0] v);
         start_val = v;
      endfunction

      function bit parser_idle();
         return phase == PH_WAIT;
      endfunction

      function int outstanding();
         return owed_results.size();
      endfunction

      function void owe(logic [STATUS_W-1:0] st, logic [LEN_W-1:0] len,
                        logic [IDX_W-1:0] idx, logic [BYTE_W-1:0] b,
                        logic valid, logic last);
         frame_result_type r;
         r.status         = st;
         r.function_code  = func_acc;
         r.payload_length = len;
         r.byte_index     = idx;
         r.payload_byte   = b;
         r.byte_valid     = valid;
         r.last           = last;
         owed_results.push_back(r);
      endfunction

      // advance the parser by one accepted byte
      function void take_byte(logic [BYTE_W-1:0] c);
         case (phase)
            PH_WAIT: begin
               if (c == start_val) begin
                  func_acc = '0;
                  len_acc  = '0;
                  count    = '0;
                  sum      = c;
                  phase    = PH_FUNC_HI;
               end
            end
            PH_FUNC_HI: begin
               func_acc = {c, 8'h00};
               sum      ^= c;
               phase    = PH_FUNC_LO;
            end
            PH_FUNC_LO: begin
               func_acc[7:0] = c;
               sum           ^= c;
               phase         = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               len_acc = {c, 8'h00};
               sum     ^= c;
               phase   = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               len_acc[7:0] = c;
               sum          ^= c;
               count        = '0;
               if (len_acc > MAX_PAYLOAD) begin
                  owe(ST_TOO_LONG, '0, '0, '0, 1'b0, 1'b1);
                  phase = PH_WAIT;
               end else if (len_acc == 0) begin
                  phase = PH_CHECK;
               end else begin
                  phase = PH_DATA;
               end
            end
            PH_DATA: begin
               store[count[IDX_W-1:0]] = c;
               sum   ^= c;
               count = count + 7'd1;
               if (count >= len_acc) phase = PH_CHECK;
            end
            PH_CHECK: begin
               if (c != sum) begin
                  owe(ST_BAD_SUM, len_acc[LEN_W-1:0], '0, '0, 1'b0, 1'b1);
               end else if (len_acc == 0) begin
                  owe(ST_OK, '0, '0, '0, 1'b0, 1'b1);
               end else begin
                  for (int i = 0; i < len_acc; i++)
                     owe(ST_OK, len_acc[LEN_W-1:0], IDX_W'(i), store[i], 1'b1,
                         i == len_acc - 1);
               end
               phase = PH_WAIT;
            end
            default: phase = PH_WAIT;
         endcase
      endfunction

      function void cmp(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            fail_count++;
         end
      endfunction

      function void check_result(frame_result_type got);
         frame_result_type want;
         if (owed_results.size() == 0) begin
            $display("%0t ns: unexpected result, status %0d function 0x%0h index %0d",
                     $time, got.status, got.function_code, got.byte_index);
            fail_count++;
            return;
         end
         want = owed_results.pop_front();
         cmp("status", 16'(want.status), 16'(got.status));
         cmp("function_code", want.function_code, got.function_code);
         cmp("payload_length", 16'(want.payload_length), 16'(got.payload_length));
         cmp("byte_index", 16'(want.byte_index), 16'(got.byte_index));
         cmp("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
         cmp("byte_valid", 16'(want.byte_valid), 16'(got.byte_valid));
         cmp("last", 16'(want.last), 16'(got.last));
      endfunction
   endclass

   logic clock;
   logic reset;

   ufd_req_if req_if ();
   ufd_rsp_if rsp_if ();
   ufd_csr_if csr_if ();

   uart_frame_decoder_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   frame_decode_tracker_type trk = new();

   logic [BYTE_W-1:0] cur_start = START_RESET;  // start byte the stimulus frames use
   bit                stall_on  = 1'b1;         // random idling on both sides
   int                bytes_sent = 0;
   int                quiet_cycles = 0;

   // 4 ns clock
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // mostly short gaps, a few long ones
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic int req_gap();
      return stall_on ? idle_len() : 0;
   endfunction

   // observe every handshake at the clock edge; inputs change only through
   // nonblocking updates, so the values seen here are the ones before the edge
   always @(posedge clock) begin
      frame_result_type got;
      bit               moved;
      if (!reset) begin
         moved = 1'b0;
         if (csr_if.valid && csr_if.ready) begin
            trk.set_start(csr_if.start_byte);
            moved = 1'b1;
         end
         if (req_if.valid && req_if.ready) begin
            trk.take_byte(req_if.rx_byte);
            moved = 1'b1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got.status         = rsp_if.status;
            got.function_code  = rsp_if.function_code;
            got.payload_length = rsp_if.payload_length;
            got.byte_index     = rsp_if.byte_index;
            got.payload_byte   = rsp_if.payload_byte;
            got.byte_valid     = rsp_if.byte_valid;
            got.last           = rsp_if.last;
            trk.check_result(got);
            moved = 1'b1;
         end
         quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      end
   end

   // the run is stuck when nothing moves for too long
   initial begin : watchdog
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("uart_frame_decoder_core verification failed");
      $finish;
   end

   // result sink: bursts of ready with random stalls in between
   initial begin
      int gap;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         gap = stall_on ? idle_len() : 0;
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // tasks below are entered right after a rising edge and return right after one;
   // send_byte leaves valid high so that the next byte can follow back to back
   task automatic send_byte(input logic [BYTE_W-1:0] b, input int gap);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.rx_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      bytes_sent++;
   endtask

   // sender pauses until every owed result has come out
   task automatic hold_until_empty();
      req_if.valid <= 1'b0;
      do @(negedge clock); while (trk.outstanding() != 0);
      @(posedge clock);
   endtask

   // quiet the block fully: a status transaction may still sit in the output stage
   task automatic drain();
      hold_until_empty();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // feed filler bytes until the parser is back to waiting for a start byte
   task automatic finish_frame();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (!trk.parser_idle()) begin
         @(posedge clock);
         send_byte(8'($urandom_range(0, 255)), 0);
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   task automatic write_start(input logic [BYTE_W-1:0] v);
      csr_if.valid      <= 1'b1;
      csr_if.start_byte <= v;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      cur_start = v;
   endtask

   // one frame with random payload; cut >= 0 keeps only that many leading bytes
   task automatic send_frame(input logic [15:0] func, input logic [15:0] len,
                             input bit bad_sum, input int cut);
      logic [BYTE_W-1:0] frame_q [$];
      logic [BYTE_W-1:0] sum;
      frame_q.push_back(cur_start);
      frame_q.push_back(func[15:8]);
      frame_q.push_back(func[7:0]);
      frame_q.push_back(len[15:8]);
      frame_q.push_back(len[7:0]);
      // an over-long length ends the frame right after the length bytes
      if (len <= MAX_PAYLOAD) begin
         for (int i = 0; i < len; i++) frame_q.push_back(8'($urandom_range(0, 255)));
         sum = '0;
         foreach (frame_q[k]) sum ^= frame_q[k];
         if (bad_sum) sum ^= 8'($urandom_range(1, 255));
         frame_q.push_back(sum);
      end
      if (cut >= 0)
         while (frame_q.size() > cut) void'(frame_q.pop_back());
      foreach (frame_q[k]) send_byte(frame_q[k], req_gap());
   endtask

   // mostly well-formed frames, with noise, corrupt sums and truncated frames mixed in
   task automatic random_frame(input bit force_max);
      logic [15:0] func;
      logic [15:0] len;
      int          sel;
      bit          bad;
      int          cut;
      sel = $urandom_range(0, 99);
      func = (sel < 10) ? 16'h0000 : (sel < 20) ? 16'hFFFF : 16'($urandom);
      sel = $urandom_range(0, 99);
      if (sel < 45)      len = 16'($urandom_range(1, 8));
      else if (sel < 57) len = 16'd0;
      else if (sel < 67) len = 16'($urandom_range(9, MAX_PAYLOAD - 1));
      else if (sel < 71) len = 16'(MAX_PAYLOAD);
      else if (sel < 78) len = 16'(MAX_PAYLOAD + 1);
      else if (sel < 85) len = 16'($urandom_range(MAX_PAYLOAD + 2, 16'hFFFF));
      else               len = 16'($urandom_range(1, 4));
      if (force_max) len = 16'(MAX_PAYLOAD);
      bad = ($urandom_range(0, 99) < 15);
      cut = ($urandom_range(0, 99) < 8 && !force_max) ? $urandom_range(1, 5) : -1;
      // stray bytes between frames; one may happen to equal the start byte
      if ($urandom_range(0, 99) < 25)
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), req_gap());
      send_frame(func, len, bad, cut);
   endtask

   initial begin
      logic [BYTE_W-1:0] start_list [NUM_PHASES];
      int                target;
      int                n;

      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.rx_byte    <= '0;
      csr_if.valid      <= 1'b0;
      csr_if.start_byte <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // first setting runs on the reset start byte; the rest are written
      start_list[0] = START_RESET;
      start_list[1] = 8'h00;
      start_list[2] = 8'hFF;
      start_list[3] = 8'($urandom_range(1, 254));
      start_list[4] = START_RESET;

      // directed: ignored bytes while waiting
      send_byte(8'h00, req_gap());
      send_byte(8'hFF, req_gap());
      // zero length with all-ones function code, good sum
      send_frame(16'hFFFF, 16'd0, 1'b0, -1);
      // one past the buffer size
      send_frame(16'h0000, 16'(MAX_PAYLOAD + 1), 1'b0, -1);
      // largest length the field can carry
      send_frame(16'h1234, 16'hFFFF, 1'b0, -1);
      // checksum mismatch on a one-byte payload
      send_frame(16'hABCD, 16'd1, 1'b1, -1);

      for (int p = 0; p < NUM_PHASES; p++) begin
         // no idling on either side in the middle setting
         stall_on = (p != 2);
         if (p > 0) begin
            finish_frame();
            drain();
            write_start(start_list[p]);
         end
         target = bytes_sent + PHASE_BYTES;
         n = 0;
         while (bytes_sent < target) begin
            random_frame(p == 1 && n == 0);
            n++;
            if (n == 3) hold_until_empty();
         end
      end

      drain();
      if (trk.fail_count == 0 && trk.outstanding() == 0)
         $display("uart_frame_decoder_core verification clean");
      else
         $display("uart_frame_decoder_core verification failed");
      $finish;
   end

endmodule
